[design/shach_pkg.sv]
// shach_pkg: shared types, round constants and sha-256 helper functions
// used by the controller, the datapath and the top level; no dependencies
`default_nettype none

package shach_pkg;

    localparam int unsigned BlockWords = 16;
    localparam int unsigned HashWords  = 8;
    localparam int unsigned Rounds     = 64;

    // controller states, one-hot
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_LOAD  = 5'b00010,
        S_ROUND = 5'b00100,
        S_FINAL = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic       byte_wr;
        logic [5:0] byte_pos;
        logic       load;
        logic [4:0] nwords;
        logic       round;
        logic [5:0] round_idx;
        logic       final_add;
        logic       emit_shift;
        logic [2:0] word_idx;
    } t_cmd;

    function automatic logic [31:0] f_init_hash(input logic [2:0] idx);
        logic [31:0] v;
        case (idx)
            3'd0:    v = 32'h6a09e667;
            3'd1:    v = 32'hbb67ae85;
            3'd2:    v = 32'h3c6ef372;
            3'd3:    v = 32'ha54ff53a;
            3'd4:    v = 32'h510e527f;
            3'd5:    v = 32'h9b05688c;
            3'd6:    v = 32'h1f83d9ab;
            3'd7:    v = 32'h5be0cd19;
            default: v = 32'h6a09e667;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] f_round_k(input logic [5:0] idx);
        logic [31:0] v;
        case (idx)
            6'd0:  v = 32'h428a2f98;  6'd1:  v = 32'h71374491;
            6'd2:  v = 32'hb5c0fbcf;  6'd3:  v = 32'he9b5dba5;
            6'd4:  v = 32'h3956c25b;  6'd5:  v = 32'h59f111f1;
            6'd6:  v = 32'h923f82a4;  6'd7:  v = 32'hab1c5ed5;
            6'd8:  v = 32'hd807aa98;  6'd9:  v = 32'h12835b01;
            6'd10: v = 32'h243185be;  6'd11: v = 32'h550c7dc3;
            6'd12: v = 32'h72be5d74;  6'd13: v = 32'h80deb1fe;
            6'd14: v = 32'h9bdc06a7;  6'd15: v = 32'hc19bf174;
            6'd16: v = 32'he49b69c1;  6'd17: v = 32'hefbe4786;
            6'd18: v = 32'h0fc19dc6;  6'd19: v = 32'h240ca1cc;
            6'd20: v = 32'h2de92c6f;  6'd21: v = 32'h4a7484aa;
            6'd22: v = 32'h5cb0a9dc;  6'd23: v = 32'h76f988da;
            6'd24: v = 32'h983e5152;  6'd25: v = 32'ha831c66d;
            6'd26: v = 32'hb00327c8;  6'd27: v = 32'hbf597fc7;
            6'd28: v = 32'hc6e00bf3;  6'd29: v = 32'hd5a79147;
            6'd30: v = 32'h06ca6351;  6'd31: v = 32'h14292967;
            6'd32: v = 32'h27b70a85;  6'd33: v = 32'h2e1b2138;
            6'd34: v = 32'h4d2c6dfc;  6'd35: v = 32'h53380d13;
            6'd36: v = 32'h650a7354;  6'd37: v = 32'h766a0abb;
            6'd38: v = 32'h81c2c92e;  6'd39: v = 32'h92722c85;
            6'd40: v = 32'ha2bfe8a1;  6'd41: v = 32'ha81a664b;
            6'd42: v = 32'hc24b8b70;  6'd43: v = 32'hc76c51a3;
            6'd44: v = 32'hd192e819;  6'd45: v = 32'hd6990624;
            6'd46: v = 32'hf40e3585;  6'd47: v = 32'h106aa070;
            6'd48: v = 32'h19a4c116;  6'd49: v = 32'h1e376c08;
            6'd50: v = 32'h2748774c;  6'd51: v = 32'h34b0bcb5;
            6'd52: v = 32'h391c0cb3;  6'd53: v = 32'h4ed8aa4a;
            6'd54: v = 32'h5b9cca4f;  6'd55: v = 32'h682e6ff3;
            6'd56: v = 32'h748f82ee;  6'd57: v = 32'h78a5636f;
            6'd58: v = 32'h84c87814;  6'd59: v = 32'h8cc70208;
            6'd60: v = 32'h90befffa;  6'd61: v = 32'ha4506ceb;
            6'd62: v = 32'hbef9a3f7;  6'd63: v = 32'hc67178f2;
            default: v = 32'h428a2f98;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] f_big_sigma0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] f_big_sigma1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] f_small_sigma0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] f_small_sigma1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

endpackage

`default_nettype wire

[design/shach_ctrl.sv]
// shach_ctrl: state machine for byte intake, round sequencing and digest output
// depends on shach_pkg
`default_nettype none

module shach_ctrl
    import shach_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    input  wire         i_in_present,
    input  wire         i_in_last,
    output logic        o_in_ready,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [2:0]  o_word_num,
    output logic        o_word_last,
    output t_cmd        o_cmd
);

    t_state      r_state, n_state;
    logic [5:0]  r_pos, n_pos;
    logic [4:0]  r_nwords, n_nwords;
    logic        r_end_pend, n_end_pend;
    logic [5:0]  r_round, n_round;
    logic [2:0]  r_word, n_word;
    logic [6:0]  w_pos_sum;
    logic [6:0]  w_pos_round;

    assign w_pos_sum   = {1'b0, r_pos} + {6'd0, i_in_present};
    assign w_pos_round = w_pos_sum + 7'd3;

    always_comb begin
        n_state    = r_state;
        n_pos      = r_pos;
        n_nwords   = r_nwords;
        n_end_pend = r_end_pend;
        n_round    = r_round;
        n_word     = r_word;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (w_pos_sum[6]) begin
                        // block full
                        n_pos      = '0;
                        n_nwords   = 5'(BlockWords);
                        n_end_pend = i_in_last;
                        n_state    = S_LOAD;
                    end else if (i_in_last) begin
                        n_pos = '0;
                        n_word = '0;
                        if (w_pos_sum != 7'd0) begin
                            n_nwords   = w_pos_round[6:2];
                            n_end_pend = 1'b1;
                            n_state    = S_LOAD;
                        end else begin
                            n_state = S_EMIT;
                        end
                    end else begin
                        n_pos = w_pos_sum[5:0];
                    end
                end
            end
            S_LOAD: begin
                n_round = '0;
                n_state = S_ROUND;
            end
            S_ROUND: begin
                n_round = r_round + 6'd1;
                if (r_round == 6'(Rounds - 1)) begin
                    n_state = S_FINAL;
                end
            end
            S_FINAL: begin
                n_word = '0;
                n_state = r_end_pend ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (i_out_ready) begin
                    n_word = r_word + 3'd1;
                    if (r_word == 3'(HashWords - 1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pos      <= '0;
            r_nwords   <= '0;
            r_end_pend <= 1'b0;
            r_round    <= '0;
            r_word     <= '0;
        end else begin
            r_state    <= n_state;
            r_pos      <= n_pos;
            r_nwords   <= n_nwords;
            r_end_pend <= n_end_pend;
            r_round    <= n_round;
            r_word     <= n_word;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_EMIT);
    assign o_word_num  = r_word;
    assign o_word_last = (r_word == 3'(HashWords - 1));

    always_comb begin
        o_cmd            = '0;
        o_cmd.byte_wr    = (r_state == S_IDLE) && i_in_valid && i_in_present;
        o_cmd.byte_pos   = r_pos;
        o_cmd.load       = (r_state == S_LOAD);
        o_cmd.nwords     = r_nwords;
        o_cmd.round      = (r_state == S_ROUND);
        o_cmd.round_idx  = r_round;
        o_cmd.final_add  = (r_state == S_FINAL);
        o_cmd.emit_shift = (r_state == S_EMIT) && i_out_ready;
        o_cmd.word_idx   = r_word;
    end

endmodule

`default_nettype wire

[design/shach_dp.sv]
// shach_dp: block buffer, message schedule window, round logic and hash state
// depends on shach_pkg
`default_nettype none

module shach_dp
    import shach_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  t_cmd        i_cmd,
    input  wire  [7:0]  i_byte,
    output logic [31:0] o_digest
);

    logic [31:0] r_block [BlockWords];
    logic [31:0] r_win   [BlockWords];
    logic [31:0] r_work  [HashWords];
    logic [31:0] r_hash  [HashWords];

    logic [31:0] w_sched;
    logic [31:0] w_t1;
    logic [31:0] w_t2;
    logic [31:0] w_ch;
    logic [31:0] w_maj;

    // next schedule word from the rolling window
    assign w_sched = f_small_sigma1(r_win[14]) + r_win[9]
                   + f_small_sigma0(r_win[1]) + r_win[0];

    assign w_ch  = (r_work[4] & r_work[5]) ^ (~r_work[4] & r_work[6]);
    assign w_maj = (r_work[0] & r_work[1]) ^ (r_work[0] & r_work[2])
                 ^ (r_work[1] & r_work[2]);
    assign w_t1  = r_work[7] + f_big_sigma1(r_work[4]) + w_ch
                 + f_round_k(i_cmd.round_idx) + r_win[0];
    assign w_t2  = f_big_sigma0(r_work[0]) + w_maj;

    // byte packing, big-endian; first byte of a word clears the rest
    always_ff @(posedge i_clk) begin
        if (i_cmd.byte_wr) begin
            case (i_cmd.byte_pos[1:0])
                2'd0:    r_block[i_cmd.byte_pos[5:2]]        <= {i_byte, 24'd0};
                2'd1:    r_block[i_cmd.byte_pos[5:2]][23:16] <= i_byte;
                2'd2:    r_block[i_cmd.byte_pos[5:2]][15:8]  <= i_byte;
                2'd3:    r_block[i_cmd.byte_pos[5:2]][7:0]   <= i_byte;
                default: r_block[i_cmd.byte_pos[5:2]][7:0]   <= i_byte;
            endcase
        end
    end

    // schedule window: loaded with zero fill, then shifts once per round
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int i = 0; i < BlockWords; i++) begin
                r_win[i] <= (5'(i) < i_cmd.nwords) ? r_block[i] : 32'd0;
            end
        end else if (i_cmd.round) begin
            for (int i = 0; i < BlockWords - 1; i++) begin
                r_win[i] <= r_win[i + 1];
            end
            r_win[BlockWords - 1] <= w_sched;
        end
    end

    // working variables a..h
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int i = 0; i < HashWords; i++) begin
                r_work[i] <= r_hash[i];
            end
        end else if (i_cmd.round) begin
            r_work[7] <= r_work[6];
            r_work[6] <= r_work[5];
            r_work[5] <= r_work[4];
            r_work[4] <= r_work[3] + w_t1;
            r_work[3] <= r_work[2];
            r_work[2] <= r_work[1];
            r_work[1] <= r_work[0];
            r_work[0] <= w_t1 + w_t2;
        end
    end

    // running hash; output shifts out word 0 and refills with initial values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HashWords; i++) begin
                r_hash[i] <= f_init_hash(3'(i));
            end
        end else if (i_cmd.final_add) begin
            for (int i = 0; i < HashWords; i++) begin
                r_hash[i] <= r_hash[i] + r_work[i];
            end
        end else if (i_cmd.emit_shift) begin
            for (int i = 0; i < HashWords - 1; i++) begin
                r_hash[i] <= r_hash[i + 1];
            end
            r_hash[HashWords - 1] <= f_init_hash(i_cmd.word_idx);
        end
    end

    assign o_digest = r_hash[0];

endmodule

`default_nettype wire

[design/sha256_chunk_hasher_core.sv]
// sha-256 chunk hasher: one byte item per cycle while idle, a 64-round compression
// per 64-byte block (a load, 64 rounds and a hash add, one shared round unit);
// digest is 8 output items after the chunk end, one per cycle when the sink is ready,
// starting directly after the chunk end (empty block) or after the load, rounds and
// hash add of the last block. synchronous active-low reset returns to idle with the
// standard initial hash; depends on shach_pkg, shach_ctrl and shach_dp
`default_nettype none

module sha256_chunk_hasher_core
    import shach_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    // input stream
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire         s_axis_tuser,   // [0] byte_present
    input  wire         s_axis_tlast,   // chunk_end
    // digest stream
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  m_axis_tuser,   // [2:0] word_number
    output logic        m_axis_tlast    // last_word
);

    t_cmd w_cmd;

    // controller: byte count, round counter, output word counter
    shach_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_present (s_axis_tuser),
        .i_in_last    (s_axis_tlast),
        .o_in_ready   (s_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_word_num   (m_axis_tuser),
        .o_word_last  (m_axis_tlast),
        .o_cmd        (w_cmd)
    );

    // datapath: block buffer, schedule, round unit, hash registers
    shach_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_byte   (s_axis_tdata),
        .o_digest (m_axis_tdata)
    );

`ifndef ASSERT_OFF
    // intake and digest output never overlap
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(m_axis_tvalid && s_axis_tready))
        else $error("input ready while digest output active");

    // after the final digest word is taken the block is ready for a new chunk
    a_back_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
        else $error("not idle after last digest word");

    // digest words leave in order without gaps
    a_word_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
        (m_axis_tvalid && (m_axis_tuser == $past(m_axis_tuser) + 3'd1)))
        else $error("digest word sequence broken");
`endif

endmodule

`default_nettype wire

[tb/sha256_chunk_hasher_core_tb.sv]
// testbench for sha256_chunk_hasher_core: byte chunks in, eight digest items out per chunk end
// self-checking against an in-bench sha-256 predictor (no padding); depends only on the rtl
`default_nettype none

module sha256_chunk_hasher_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400000;   // far above the slowest legal run
    localparam int DRAIN_CYCLES = 150;      // more than one compression plus emit
    localparam int ITEM_TARGET  = 350;

    localparam logic [31:0] HASH_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // one input item as the sender holds it
    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       chunk_end;
    } t_byte_item;

    // one digest item as the receiver should see it
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  number;
        logic        last;
    } t_digest_item;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;

    // sender side, all known from time zero
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata  = 8'd0;   // [7:0] data_byte
    logic        s_tuser  = 1'b0;   // [0] byte_present
    logic        s_tlast  = 1'b0;   // chunk_end
    wire         s_axis_tready;

    // receiver side
    logic        m_tready = 1'b0;
    wire         m_axis_tvalid;
    wire  [31:0] m_axis_tdata;      // [31:0] digest_word
    wire  [2:0]  m_axis_tuser;      // [2:0] word_number
    wire         m_axis_tlast;      // last_word

    t_byte_item   pending_items[$];
    t_digest_item digest_queue[$];

    // predictor state
    logic [31:0] msg_block [16];
    logic [5:0]  fill_pos;
    logic [31:0] chain_hash [8];

    int total_items    = 0;
    int accepted_items = 0;
    int chunk_count    = 0;
    int byte_count     = 0;
    int words_checked  = 0;
    int fail_count     = 0;
    int cycle_count    = 0;

    sha256_chunk_hasher_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .s_axis_tlast  (s_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ---------------- sha-256 predictor ----------------

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    // 64 rounds over msg_block, folded into chain_hash
    task automatic compress_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2;
        int r;
        for (r = 0; r < 16; r++) w[r] = msg_block[r];
        for (r = 16; r < 64; r++)
            w[r] = ssig1(w[r-2]) + w[r-7] + ssig0(w[r-15]) + w[r-16];
        for (r = 0; r < 8; r++) v[r] = chain_hash[r];
        for (r = 0; r < 64; r++) begin
            t1 = v[7] + bsig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + w[r];
            t2 = bsig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (r = 0; r < 8; r++) chain_hash[r] = chain_hash[r] + v[r];
    endtask

    // apply one accepted input item, queue the digest items it causes
    task automatic absorb_item(input t_byte_item it);
        t_digest_item dw;
        int k;
        if (it.present) begin
            // first byte of a word clears it, bytes land big-endian
            if (fill_pos[1:0] == 2'd0) msg_block[fill_pos[5:2]] = 32'd0;
            msg_block[fill_pos[5:2]] = msg_block[fill_pos[5:2]]
                | ({24'd0, it.data} << (8 * (3 - int'(fill_pos[1:0]))));
            byte_count++;
            if (fill_pos == 6'd63) begin
                compress_block();
                fill_pos = 6'd0;
            end else begin
                fill_pos = fill_pos + 6'd1;
            end
        end
        if (it.chunk_end) begin
            // partial block is zero-filled, an exact multiple gets no extra block
            if (fill_pos != 6'd0) begin
                for (k = (int'(fill_pos) + 3) >> 2; k < 16; k++) msg_block[k] = 32'd0;
                compress_block();
                fill_pos = 6'd0;
            end
            for (k = 0; k < 8; k++) begin
                dw.word   = chain_hash[k];
                dw.number = 3'(k);
                dw.last   = (k == 7);
                digest_queue.push_back(dw);
                chain_hash[k] = HASH_IV[k];
            end
            chunk_count++;
        end
    endtask

    // ---------------- stimulus building ----------------

    task automatic push_item(input logic [7:0] data, input logic present, input logic last);
        t_byte_item it;
        it.data      = data;
        it.present   = present;
        it.chunk_end = last;
        pending_items.push_back(it);
        total_items++;
    endtask

    // a chunk of random bytes, idle noise sprinkled in, ended on the last byte
    // or by an empty end marker
    task automatic add_chunk(input int nbytes, input bit marker_end);
        int b;
        for (b = 0; b < nbytes; b++) begin
            if ($urandom_range(99) < 8) push_item(8'($urandom), 1'b0, 1'b0);
            push_item(8'($urandom), 1'b1, (b == nbytes - 1) && !marker_end);
        end
        if (marker_end || nbytes == 0) push_item(8'($urandom), 1'b0, 1'b1);
    endtask

    // idling shifts with progress: sender light / receiver heavy, then swapped, then none
    function automatic int idle_phase();
        if (total_items == 0) return 0;
        return (accepted_items * 3) / total_items;
    endfunction

    // ---------------- driver ----------------

    always @(posedge i_clk) begin : drive_items
        t_byte_item nxt;
        int idle_pct;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_axis_tready) begin
            case (idle_phase())
                0:       idle_pct = 24;
                1:       idle_pct = 85;
                default: idle_pct = 0;
            endcase
            if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
                nxt = pending_items.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= nxt.data;
                s_tuser  <= nxt.present;
                s_tlast  <= nxt.chunk_end;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver stalls
    always @(posedge i_clk) begin : drive_ready
        int idle_pct;
        case (idle_phase())
            0:       idle_pct = 85;
            1:       idle_pct = 24;
            default: idle_pct = 0;
        endcase
        if (!i_rst_n) m_tready <= 1'b0;
        else          m_tready <= ($urandom_range(99) >= idle_pct);
    end

    // ---------------- monitors ----------------

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    // input side: every accepted item goes through the predictor
    always @(posedge i_clk) begin : watch_input
        t_byte_item it;
        if (i_rst_n && s_tvalid && s_axis_tready) begin
            it.data      = s_tdata;
            it.present   = s_tuser;
            it.chunk_end = s_tlast;
            absorb_item(it);
            accepted_items++;
        end
    end

    // output side: compare each digest item with the oldest expectation
    always @(posedge i_clk) begin : watch_digest
        t_digest_item exp_item;
        if (i_rst_n && m_axis_tvalid && m_tready) begin
            if (digest_queue.size() == 0) begin
                note_failure($sformatf("unexpected digest item word %08h number %0d last %0b",
                                       m_axis_tdata, m_axis_tuser, m_axis_tlast));
            end else begin
                exp_item = digest_queue.pop_front();
                words_checked++;
                if (m_axis_tdata !== exp_item.word || m_axis_tuser !== exp_item.number
                        || m_axis_tlast !== exp_item.last)
                    note_failure($sformatf(
                        "expected word %08h number %0d last %0b, got %08h %0d %0b",
                        exp_item.word, exp_item.number, exp_item.last,
                        m_axis_tdata, m_axis_tuser, m_axis_tlast));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d digest items still expected",
                     cycle_count, digest_queue.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // ---------------- sequence ----------------

    initial begin : main_seq
        int r;
        int k;
        for (k = 0; k < 16; k++) msg_block[k] = 32'd0;
        for (k = 0; k < 8; k++) chain_hash[k] = HASH_IV[k];
        fill_pos = 6'd0;

        // directed part
        push_item(8'hff, 1'b0, 1'b0);           // idle item, ignored
        push_item(8'h00, 1'b0, 1'b1);           // empty chunk gives the initial values
        push_item(8'h00, 1'b1, 1'b1);           // single zero byte ending the chunk
        push_item(8'hff, 1'b1, 1'b0);           // single byte, then an empty end marker
        push_item(8'h5a, 1'b0, 1'b1);
        push_item(8'ha5, 1'b0, 1'b0);           // idle with data set
        for (k = 0; k < 4; k++)                 // one full word of ones
            push_item(8'hff, 1'b1, k == 3);
        push_item(8'h80, 1'b1, 1'b0);           // five bytes, partial second word
        push_item(8'h01, 1'b1, 1'b0);
        push_item(8'h7f, 1'b1, 1'b0);
        push_item(8'hfe, 1'b1, 1'b0);
        push_item(8'h00, 1'b1, 1'b1);
        push_item(8'h00, 1'b0, 1'b1);           // back-to-back empty chunks
        push_item(8'hff, 1'b0, 1'b1);

        // exact block multiples and the edges around one block
        add_chunk(64, 1'b0);
        add_chunk(64, 1'b1);
        add_chunk(63, 1'b0);
        add_chunk(65, 1'b1);

        // random chunks, mostly short, now and then a block or two long;
        // stop short of the target to leave room for the last chunk
        while (total_items < ITEM_TARGET - 30) begin
            r = $urandom_range(99);
            if (r < 55)      add_chunk($urandom_range(8), $urandom_range(1));
            else if (r < 82) add_chunk($urandom_range(63, 9), $urandom_range(1));
            else if (r < 92) add_chunk($urandom_range(1) ? 64 : 128, $urandom_range(1));
            else             add_chunk($urandom_range(70, 65), $urandom_range(1));
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all items handed over, then all digests back, then a quiet tail
        while (pending_items.size() != 0 || s_tvalid) @(posedge i_clk);
        while (digest_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d chunks, %0d bytes in %0d items, %0d digest words checked",
                 chunk_count, byte_count, accepted_items, words_checked);
        $display("idle mixes: light/heavy, heavy/light, none; failures %0d", fail_count);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
